// ===== rtl/block_cache_directory_random_evict_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the cache directory block
// Shared helpers so each check is one line at the point of use.
// ---------------------------------------------------------------------------
`ifndef BLOCK_CACHE_DIRECTORY_RANDOM_EVICT_MACROS_SVH
`define BLOCK_CACHE_DIRECTORY_RANDOM_EVICT_MACROS_SVH

// condition must hold on every clock outside reset
`define BCDRE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BCDRE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/bcdre_pkg.sv =====
// ---------------------------------------------------------------------------
// bcdre_pkg
// Types, constants and helpers shared by the cache directory modules.
// ---------------------------------------------------------------------------
package bcdre_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int BLOCK_BYTES = 4096;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int FQ_DEPTH    = 2;
  localparam int OQ_DEPTH    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  // request codes
  localparam logic [2:0] REQ_READ  = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_FLUSH = 3'd2;
  localparam logic [2:0] REQ_DROP  = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 1'd1;

  typedef enum logic [2:0] {
    KIND_READ, KIND_WRITE, KIND_FLUSH, KIND_DROP, KIND_CLEAR
  } kind_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  file_id;
    logic [31:0] block_number;
    logic [11:0] byte_offset;
    logic [12:0] chunk_length;
    logic [12:0] fill_length;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [12:0] bytes_done;
    logic        stop;
    logic [12:0] entry_length;
    logic        wb_valid;
    logic [9:0]  wb_file;
    logic [31:0] wb_block;
    logic [12:0] wb_length;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic        last;
  } out_t;

  // classified request passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [9:0]  file;
    logic [31:0] block;
    logic [11:0] off;
    logic [12:0] chunk;
    logic [12:0] fill;
  } cmd_t;

  // one directory entry in the tag memory
  typedef struct packed {
    logic [9:0]  file;
    logic [31:0] block;
    logic [12:0] bytes;
  } ent_t;

  typedef struct packed {
    logic              we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic [OCC_W-1:0] occ;
  } stat_t;

  // one shift of the Galois LFSR
  function automatic logic [31:0] lfsr_step(input logic [31:0] v);
    logic [31:0] s;
    s = v >> 1;
    if (v[0]) s = s ^ LFSR_TAPS;
    return s;
  endfunction

  // limit clamped to 1..MAX_ENTRIES
  function automatic logic [OCC_W-1:0] lim_eff(input logic [6:0] l);
    int v;
    v = int'(l);
    if (v == 0) v = 1;
    if (v > MAX_ENTRIES) v = MAX_ENTRIES;
    return OCC_W'(v);
  endfunction

  // chunk saturated to the room left in the block
  function automatic logic [12:0] chunk_sat(input logic [11:0] off, input logic [12:0] clen);
    int room;
    room = (int'(off) < BLOCK_BYTES) ? BLOCK_BYTES - int'(off) : 0;
    return (int'(clen) < room) ? clen : 13'(room);
  endfunction

  function automatic logic [12:0] fill_sat(input logic [12:0] f);
    return (int'(f) > BLOCK_BYTES) ? 13'(BLOCK_BYTES) : f;
  endfunction

endpackage

// ===== rtl/bcdre_ram.sv =====
// ---------------------------------------------------------------------------
// bcdre_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module bcdre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bcdre_front.sv =====
// ---------------------------------------------------------------------------
// bcdre_front
// Accepts request items, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
module bcdre_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  bcdre_pkg::in_t        request,
  output logic                  cmd_valid,
  input  logic                  cmd_take,
  output bcdre_pkg::cmd_t       cmd
);

  localparam int PW = (bcdre_pkg::FQ_DEPTH > 1) ? $clog2(bcdre_pkg::FQ_DEPTH) : 1;
  localparam int CW = $clog2(bcdre_pkg::FQ_DEPTH + 1);

  bcdre_pkg::cmd_t q [bcdre_pkg::FQ_DEPTH];
  logic [PW-1:0]   head;
  logic [PW-1:0]   tail;
  logic [CW-1:0]   count;
  bcdre_pkg::cmd_t cls;
  logic            known;
  logic            enq;
  logic            deq;

  // classify the incoming item
  always_comb begin
    cls.file  = request.file_id;
    cls.block = request.block_number;
    cls.off   = request.byte_offset;
    cls.chunk = bcdre_pkg::chunk_sat(request.byte_offset, request.chunk_length);
    cls.fill  = bcdre_pkg::fill_sat(request.fill_length);
    known     = 1'b1;
    unique case (request.req_type)
      bcdre_pkg::REQ_READ:  cls.kind = bcdre_pkg::KIND_READ;
      bcdre_pkg::REQ_WRITE: cls.kind = bcdre_pkg::KIND_WRITE;
      bcdre_pkg::REQ_FLUSH: cls.kind = bcdre_pkg::KIND_FLUSH;
      bcdre_pkg::REQ_DROP:  cls.kind = bcdre_pkg::KIND_DROP;
      bcdre_pkg::REQ_CLEAR: cls.kind = bcdre_pkg::KIND_CLEAR;
      default: begin
        cls.kind = bcdre_pkg::KIND_CLEAR;
        known    = 1'b0;
      end
    endcase
  end

  assign full      = (count == CW'(bcdre_pkg::FQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[head];
  // unknown codes are accepted and dropped
  assign enq       = push && !full && known;
  assign deq       = cmd_take && cmd_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (enq) q[tail] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (enq) tail <= (tail == PW'(bcdre_pkg::FQ_DEPTH - 1)) ? '0 : tail + 1'b1;
      if (deq) head <= (head == PW'(bcdre_pkg::FQ_DEPTH - 1)) ? '0 : head + 1'b1;
      count <= count + CW'(enq) - CW'(deq);
    end
  end

endmodule

// ===== rtl/bcdre_outq.sv =====
// ---------------------------------------------------------------------------
// bcdre_outq
// Short result queue between the back end and the result ports.
// ---------------------------------------------------------------------------
module bcdre_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  bcdre_pkg::out_t  wdata,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output bcdre_pkg::out_t  result
);

  localparam int PW = (bcdre_pkg::OQ_DEPTH > 1) ? $clog2(bcdre_pkg::OQ_DEPTH) : 1;
  localparam int CW = $clog2(bcdre_pkg::OQ_DEPTH + 1);

  bcdre_pkg::out_t q [bcdre_pkg::OQ_DEPTH];
  logic [PW-1:0]   head;
  logic [PW-1:0]   tail;
  logic [CW-1:0]   count;
  logic            enq;
  logic            deq;

  assign full   = (count == CW'(bcdre_pkg::OQ_DEPTH));
  assign empty  = (count == '0);
  assign result = q[head];
  assign enq    = wr && !full;
  assign deq    = pop && !empty;

  always_ff @(posedge clk) begin
    if (enq) q[tail] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (enq) tail <= (tail == PW'(bcdre_pkg::OQ_DEPTH - 1)) ? '0 : tail + 1'b1;
      if (deq) head <= (head == PW'(bcdre_pkg::OQ_DEPTH - 1)) ? '0 : head + 1'b1;
      count <= count + CW'(enq) - CW'(deq);
    end
  end

endmodule

// ===== rtl/bcdre_back.sv =====
// ---------------------------------------------------------------------------
// bcdre_back
// Directory engine: lookup scan, victim choice, insert, update, flush, drop and counter clear.
// ---------------------------------------------------------------------------
module bcdre_back (
  input  logic             clk,
  input  logic             rst,
  input  bcdre_pkg::cfg_t  cfg,
  input  logic             cmd_valid,
  output logic             cmd_take,
  input  bcdre_pkg::cmd_t  cmd,
  output logic             oq_wr,
  output bcdre_pkg::out_t  oq_data,
  input  logic             oq_full,
  output bcdre_pkg::stat_t stat
);

  localparam int IW = bcdre_pkg::IDX_W;
  localparam int OW = bcdre_pkg::OCC_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(bcdre_pkg::MAX_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LK_RD, S_LK_CMP, S_MISS, S_DIV, S_VSEL, S_VRD, S_VCHK,
    S_INS, S_OP, S_EMIT, S_FL_RD, S_FL_CHK, S_FL_END
  } state_t;

  typedef struct packed {
    logic        hit;
    logic [12:0] bytes;
    logic        stop;
    logic [12:0] elen;
    logic        wbv;
    logic [9:0]  wbf;
    logic [31:0] wbb;
    logic [12:0] wbl;
  } res_t;

  state_t                       state;
  bcdre_pkg::cmd_t              c;
  res_t                         r;
  logic [bcdre_pkg::MAX_ENTRIES-1:0] valid;
  logic [bcdre_pkg::MAX_ENTRIES-1:0] dirty;
  logic [OW-1:0]                occ;
  logic [6:0]                   block_limit;
  logic [31:0]                  lfsr;
  logic [31:0]                  hit_cnt;
  logic [31:0]                  miss_cnt;
  logic [IW-1:0]                rd_addr;
  logic [IW-1:0]                vptr;
  logic [IW-1:0]                victim;
  logic [IW-1:0]                free;
  logic                         free_found;
  logic [IW-1:0]                slot;
  logic [12:0]                  len;
  logic [31:0]                  dividend;
  logic [OW-1:0]                rem;
  logic [4:0]                   div_cnt;
  bcdre_pkg::ent_t              pend;
  logic                         pend_v;

  logic [$bits(bcdre_pkg::ent_t)-1:0] rdata_raw;
  bcdre_pkg::ent_t              rd_ent;
  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  bcdre_pkg::ent_t              ram_wdata;
  logic                         match;
  logic                         fl_match;
  logic [OW:0]                  trial;
  logic [12:0]                  wr_end;
  logic [12:0]                  new_len;
  logic [12:0]                  avail;
  logic [31:0]                  lfsr_n;

  assign rd_ent    = bcdre_pkg::ent_t'(rdata_raw);
  assign stat.occ  = occ;
  assign cmd_take  = (state == S_IDLE);
  assign match     = valid[rd_addr] && rd_ent.file == c.file && rd_ent.block == c.block;
  assign fl_match  = valid[rd_addr] && dirty[rd_addr] && rd_ent.file == c.file;
  assign trial     = {rem, dividend[31]};
  assign lfsr_n    = bcdre_pkg::lfsr_step(lfsr);
  assign avail     = len - {1'b0, c.off};

  // write end and grown length for a write chunk
  always_comb begin
    logic [13:0] e;
    e      = {2'b0, c.off} + {1'b0, c.chunk};
    wr_end = (int'(e) > bcdre_pkg::BLOCK_BYTES) ? 13'(bcdre_pkg::BLOCK_BYTES) : e[12:0];
    new_len = (len < wr_end) ? wr_end : len;
  end

  // tag memory write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = '{file: c.file, block: c.block, bytes: new_len};
    if (state == S_INS && free_found &&
        !(c.kind == bcdre_pkg::KIND_READ && c.fill == '0)) begin
      ram_we          = 1'b1;
      ram_waddr       = free;
      ram_wdata.bytes = c.fill;
    end else if (state == S_OP && c.kind == bcdre_pkg::KIND_WRITE) begin
      ram_we = 1'b1;
    end
  end

  bcdre_ram #(
    .WIDTH($bits(bcdre_pkg::ent_t)),
    .DEPTH(bcdre_pkg::MAX_ENTRIES)
  ) u_tags (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(rdata_raw)
  );

  // result queue write
  always_comb begin
    oq_wr   = 1'b0;
    oq_data = '0;
    oq_data.hit_total  = hit_cnt;
    oq_data.miss_total = miss_cnt;
    unique case (state) inside
      S_EMIT: begin
        oq_wr                 = 1'b1;
        oq_data.hit           = r.hit;
        oq_data.bytes_done    = r.bytes;
        oq_data.stop          = r.stop;
        oq_data.entry_length  = r.elen;
        oq_data.wb_valid      = r.wbv;
        oq_data.wb_file       = r.wbf;
        oq_data.wb_block      = r.wbb;
        oq_data.wb_length     = r.wbl;
        oq_data.last          = 1'b1;
      end
      S_FL_CHK, S_FL_END: begin
        oq_wr = (state == S_FL_END) || (fl_match && pend_v);
        if (pend_v) begin
          oq_data.wb_valid     = 1'b1;
          oq_data.wb_file      = pend.file;
          oq_data.wb_block     = pend.block;
          oq_data.wb_length    = pend.bytes;
          oq_data.entry_length = pend.bytes;
        end
        oq_data.last = (state == S_FL_END);
      end
      default: oq_wr = 1'b0;
    endcase
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid       <= '0;
      dirty       <= '0;
      occ         <= '0;
      block_limit <= 7'd64;
      lfsr        <= 32'd1;
      hit_cnt     <= '0;
      miss_cnt    <= '0;
      pend_v      <= 1'b0;
      free_found  <= 1'b0;
      rd_addr     <= '0;
    end else begin
      // configuration writes
      if (cfg.we) begin
        if (cfg.index == bcdre_pkg::REG_BLOCK_LIMIT) block_limit <= cfg.data[6:0];
        if (cfg.index == bcdre_pkg::REG_RANDOM_SEED)
          lfsr <= (cfg.data == '0) ? 32'd1 : cfg.data;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            c          <= cmd;
            r          <= '0;
            rd_addr    <= '0;
            free_found <= 1'b0;
            pend_v     <= 1'b0;
            unique case (cmd.kind) inside
              bcdre_pkg::KIND_READ, bcdre_pkg::KIND_WRITE: state <= S_LK_RD;
              bcdre_pkg::KIND_FLUSH: state <= S_FL_RD;
              bcdre_pkg::KIND_DROP: begin
                valid <= '0;
                dirty <= '0;
                occ   <= '0;
                state <= S_EMIT;
              end
              default: begin
                hit_cnt  <= '0;
                miss_cnt <= '0;
                state    <= S_EMIT;
              end
            endcase
          end
        end
        S_LK_RD: state <= S_LK_CMP;
        // compare one entry per visit, note the lowest free slot
        S_LK_CMP: begin
          if (match) begin
            hit_cnt <= hit_cnt + 32'd1;
            r.hit   <= 1'b1;
            slot    <= rd_addr;
            len     <= rd_ent.bytes;
            state   <= S_OP;
          end else begin
            if (!valid[rd_addr] && !free_found) begin
              free       <= rd_addr;
              free_found <= 1'b1;
            end
            if (rd_addr == LAST_IDX) state <= S_MISS;
            else begin
              rd_addr <= rd_addr + 1'b1;
              state   <= S_LK_RD;
            end
          end
        end
        S_MISS: begin
          miss_cnt <= miss_cnt + 32'd1;
          if (occ >= bcdre_pkg::lim_eff(block_limit) && occ != '0) begin
            lfsr     <= lfsr_n;
            dividend <= lfsr_n;
            rem      <= '0;
            div_cnt  <= '0;
            state    <= S_DIV;
          end else begin
            state <= S_INS;
          end
        end
        // restoring remainder, one dividend bit per cycle
        S_DIV: begin
          dividend <= dividend << 1;
          if (trial >= {1'b0, occ}) rem <= OW'(trial - {1'b0, occ});
          else rem <= trial[OW-1:0];
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            vptr  <= '0;
            state <= S_VSEL;
          end
        end
        // walk valid bits to the entry of the chosen rank
        S_VSEL: begin
          if (valid[vptr] && rem == '0) begin
            victim  <= vptr;
            rd_addr <= vptr;
            state   <= S_VRD;
          end else begin
            if (valid[vptr]) rem <= rem - 1'b1;
            vptr <= vptr + 1'b1;
            if (vptr == LAST_IDX) state <= S_INS;
          end
        end
        S_VRD: state <= S_VCHK;
        S_VCHK: begin
          if (dirty[victim]) begin
            r.wbv <= 1'b1;
            r.wbf <= rd_ent.file;
            r.wbb <= rd_ent.block;
            r.wbl <= rd_ent.bytes;
          end
          valid[victim] <= 1'b0;
          dirty[victim] <= 1'b0;
          occ           <= occ - 1'b1;
          if (!free_found || victim < free) free <= victim;
          free_found <= 1'b1;
          state      <= S_INS;
        end
        S_INS: begin
          if (c.kind == bcdre_pkg::KIND_READ && c.fill == '0) begin
            r.stop <= 1'b1;
            state  <= S_EMIT;
          end else if (!free_found) begin
            r.stop <= (c.kind == bcdre_pkg::KIND_READ);
            state  <= S_EMIT;
          end else begin
            valid[free] <= 1'b1;
            dirty[free] <= 1'b0;
            occ         <= occ + 1'b1;
            slot        <= free;
            len         <= c.fill;
            state       <= S_OP;
          end
        end
        S_OP: begin
          if (c.kind == bcdre_pkg::KIND_WRITE) begin
            dirty[slot] <= 1'b1;
            r.bytes     <= c.chunk;
            r.elen      <= new_len;
          end else begin
            r.elen <= len;
            if (len <= {1'b0, c.off}) r.stop <= 1'b1;
            else r.bytes <= (c.chunk < avail) ? c.chunk : avail;
          end
          state <= S_EMIT;
        end
        S_EMIT: if (!oq_full) state <= S_IDLE;
        S_FL_RD: state <= S_FL_CHK;
        // hold the newest match back so the final one can carry last
        S_FL_CHK: begin
          if (!(fl_match && pend_v && oq_full)) begin
            if (fl_match) begin
              pend           <= rd_ent;
              pend_v         <= 1'b1;
              dirty[rd_addr] <= 1'b0;
            end
            if (rd_addr == LAST_IDX) state <= S_FL_END;
            else begin
              rd_addr <= rd_addr + 1'b1;
              state   <= S_FL_RD;
            end
          end
        end
        S_FL_END: if (!oq_full) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/block_cache_directory_random_evict.sv =====
// A read or write scans the tag entries in order until it hits; a miss scans all 64
// entries, then computes a random remainder and walks the valid bits to a victim
// when it evicts. A flush scans all 64 entries and can be held by output stalls.
// The back end handles one item at a time and takes no new item until the last is emitted.
// Reset is synchronous: all entries invalid, counters zero, limit 64, LFSR 1.
// ---------------------------------------------------------------------------
// block_cache_directory_random_evict
// Fully associative write-back block directory with random replacement.
// ---------------------------------------------------------------------------
`include "block_cache_directory_random_evict_macros.svh"

module block_cache_directory_random_evict (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  bcdre_pkg::in_t                      request,
  output logic                                empty,
  input  logic                                pop,
  output bcdre_pkg::out_t                     result,
  input  logic                                cfg_write,
  input  logic [bcdre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcdre_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic             cmd_valid;
  logic             cmd_take;
  bcdre_pkg::cmd_t  cmd;
  logic             oq_wr;
  logic             oq_full;
  bcdre_pkg::out_t  oq_data;
  bcdre_pkg::cfg_t  cfg;
  bcdre_pkg::stat_t stat;

  assign cfg.we    = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  bcdre_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd      (cmd)
  );

  bcdre_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd      (cmd),
    .oq_wr    (oq_wr),
    .oq_data  (oq_data),
    .oq_full  (oq_full),
    .stat     (stat)
  );

  bcdre_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (oq_wr),
    .wdata (oq_data),
    .full  (oq_full),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  // checks
  `BCDRE_ASSERT_ALWAYS(a_occ_range, int'(stat.occ) <= bcdre_pkg::MAX_ENTRIES, "occupancy overflow")
  `BCDRE_ASSERT_IMP(a_hit_no_wb, !empty && result.hit, !result.wb_valid, "write-back on a hit")
  `BCDRE_ASSERT_IMP(a_stop_zero, !empty && result.stop, result.bytes_done == '0, "stop with bytes")

endmodule

// ===== dv/tb_block_cache_directory_random_evict.sv =====
// ---------------------------------------------------------------------------
// tb_block_cache_directory_random_evict
// Self-checking bench for the block cache directory: a directed opening, then
// random read/write/flush/drop/clear and unknown-code traffic over a small set
// of files and blocks, with random idle bursts on both sides. A behavioural
// directory model predicts every result item and a scoreboard checks them in order.
// ---------------------------------------------------------------------------
module tb_block_cache_directory_random_evict;
  timeunit 1ns;
  timeprecision 1ps;

  // scoreboard: holds predicted result items, checks them in order
  class result_board;
    bcdre_pkg::out_t pending[$];
    int   errors;

    function void note(bcdre_pkg::out_t r);
      pending.push_back(r);
    endfunction

    // one line per mismatch, and count it
    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check(bcdre_pkg::out_t got);
      bcdre_pkg::out_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result item %h", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) report($sformatf("got %h want %h", got, want));
    endtask
  endclass

  logic clk, rst, push, full, empty, pop, cfg_write;
  bcdre_pkg::in_t  request;
  bcdre_pkg::out_t result;
  logic [bcdre_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bcdre_pkg::CFG_DATA_W-1:0] cfg_data;

  result_board board;
  longint cycles;
  bit calm;

  // directory model state
  bit          dir_valid[bcdre_pkg::MAX_ENTRIES];
  bit          dir_dirty[bcdre_pkg::MAX_ENTRIES];
  logic [9:0]  dir_file[bcdre_pkg::MAX_ENTRIES];
  logic [31:0] dir_block[bcdre_pkg::MAX_ENTRIES];
  logic [12:0] dir_bytes[bcdre_pkg::MAX_ENTRIES];
  int          dir_occ;
  logic [31:0] rand_state, hits, misses;
  logic [6:0]  limit_reg;

  block_cache_directory_random_evict u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // model: register write
  function automatic void model_config(logic [bcdre_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
    if (idx == bcdre_pkg::REG_BLOCK_LIMIT) limit_reg = v[6:0];
    else rand_state = (v == 0) ? 32'd1 : v;
  endfunction

  // model: one request, pushes the predicted result items
  function automatic void predict_directory(bcdre_pkg::in_t q);
    bcdre_pkg::out_t r;
    int room, chunk, fill, lim, slot, rank, n, len, fin;
    logic lsb;
    r = '0;
    room = (q.byte_offset < bcdre_pkg::BLOCK_BYTES) ?
           bcdre_pkg::BLOCK_BYTES - q.byte_offset : 0;
    chunk = (q.chunk_length < room) ? q.chunk_length : room;
    fill = (q.fill_length > bcdre_pkg::BLOCK_BYTES) ? bcdre_pkg::BLOCK_BYTES : q.fill_length;
    r.last = 1;
    case (q.req_type) inside
      bcdre_pkg::REQ_READ, bcdre_pkg::REQ_WRITE: begin
        slot = -1;
        for (int i = 0; i < bcdre_pkg::MAX_ENTRIES; i++)
          if (slot < 0 && dir_valid[i] && dir_file[i] == q.file_id &&
              dir_block[i] == q.block_number) slot = i;
        if (slot >= 0) begin
          hits++;
          r.hit = 1;
        end else begin
          misses++;
          lim = (limit_reg == 0) ? 1 : (limit_reg > bcdre_pkg::MAX_ENTRIES ?
                                        bcdre_pkg::MAX_ENTRIES : limit_reg);
          if (dir_occ >= lim && dir_occ > 0) begin
            lsb = rand_state[0];
            rand_state = rand_state >> 1;
            if (lsb) rand_state ^= bcdre_pkg::LFSR_TAPS;
            rank = rand_state % dir_occ;
            for (int i = 0; i < bcdre_pkg::MAX_ENTRIES; i++) begin
              if (dir_valid[i]) begin
                if (rank == 0) begin
                  if (dir_dirty[i]) begin
                    r.wb_valid = 1;
                    r.wb_file = dir_file[i];
                    r.wb_block = dir_block[i];
                    r.wb_length = dir_bytes[i];
                  end
                  dir_valid[i] = 0;
                  dir_dirty[i] = 0;
                  dir_occ--;
                  break;
                end
                rank--;
              end
            end
          end
          if (q.req_type == bcdre_pkg::REQ_READ && fill == 0) begin
            r.stop = 1;
            r.hit_total = hits;
            r.miss_total = misses;
            board.note(r);
            return;
          end
          for (int i = 0; i < bcdre_pkg::MAX_ENTRIES; i++)
            if (slot < 0 && !dir_valid[i]) slot = i;
          dir_valid[slot] = 1;
          dir_dirty[slot] = 0;
          dir_file[slot] = q.file_id;
          dir_block[slot] = q.block_number;
          dir_bytes[slot] = fill;
          dir_occ++;
        end
        len = dir_bytes[slot];
        if (q.req_type == bcdre_pkg::REQ_READ) begin
          if (len <= q.byte_offset) r.stop = 1;
          else r.bytes_done = (chunk < len - q.byte_offset) ? chunk : len - q.byte_offset;
        end else begin
          fin = q.byte_offset + chunk;
          if (fin > bcdre_pkg::BLOCK_BYTES) fin = bcdre_pkg::BLOCK_BYTES;
          dir_dirty[slot] = 1;
          if (len < fin) dir_bytes[slot] = fin;
          r.bytes_done = chunk;
        end
        r.entry_length = dir_bytes[slot];
        r.hit_total = hits;
        r.miss_total = misses;
        board.note(r);
      end
      bcdre_pkg::REQ_FLUSH: begin
        n = 0;
        for (int i = 0; i < bcdre_pkg::MAX_ENTRIES; i++)
          if (dir_valid[i] && dir_dirty[i] && dir_file[i] == q.file_id) n++;
        if (n == 0) begin
          r.hit_total = hits;
          r.miss_total = misses;
          board.note(r);
        end
        for (int i = 0; i < bcdre_pkg::MAX_ENTRIES; i++)
          if (dir_valid[i] && dir_dirty[i] && dir_file[i] == q.file_id) begin
            r = '0;
            r.wb_valid = 1;
            r.wb_file = dir_file[i];
            r.wb_block = dir_block[i];
            r.wb_length = dir_bytes[i];
            r.entry_length = dir_bytes[i];
            r.hit_total = hits;
            r.miss_total = misses;
            n--;
            r.last = (n == 0);
            dir_dirty[i] = 0;
            board.note(r);
          end
      end
      bcdre_pkg::REQ_DROP, bcdre_pkg::REQ_CLEAR: begin
        if (q.req_type == bcdre_pkg::REQ_DROP) begin
          for (int i = 0; i < bcdre_pkg::MAX_ENTRIES; i++) begin
            dir_valid[i] = 0;
            dir_dirty[i] = 0;
          end
          dir_occ = 0;
        end else begin
          hits = 0;
          misses = 0;
        end
        r.hit_total = hits;
        r.miss_total = misses;
        board.note(r);
      end
      default: ;
    endcase
  endfunction

  // random idle burst, none once the run is calm
  task automatic idle_burst(input int pct);
    if (!calm && $urandom_range(99) < pct) begin
      push <= 0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
  endtask

  // push one item, predicting at acceptance; push stays up for the next item
  task automatic send_item(bcdre_pkg::in_t q);
    idle_burst(20);
    push <= 1;
    request <= q;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_directory(q);
  endtask

  task automatic drain_wait(input int extra);
    push <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [bcdre_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
    drain_wait(400);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    model_config(idx, v);
  endtask

  function automatic bcdre_pkg::in_t make_item(logic [2:0] kind, logic [9:0] f,
                                               logic [31:0] b, logic [11:0] off,
                                               logic [12:0] cl, logic [12:0] fl);
    bcdre_pkg::in_t q;
    q.req_type = kind;
    q.file_id = f;
    q.block_number = b;
    q.byte_offset = off;
    q.chunk_length = cl;
    q.fill_length = fl;
    return q;
  endfunction

  // random item, mostly from a small pool of files and blocks to get hits
  function automatic bcdre_pkg::in_t random_item();
    bcdre_pkg::in_t q;
    int k;
    k = $urandom_range(99);
    q.req_type = (k < 45) ? bcdre_pkg::REQ_READ : (k < 80) ? bcdre_pkg::REQ_WRITE :
                 (k < 92) ? bcdre_pkg::REQ_FLUSH : (k < 95) ? bcdre_pkg::REQ_DROP :
                 (k < 97) ? bcdre_pkg::REQ_CLEAR : 3'($urandom_range(7, 5));
    q.file_id = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(3));
    q.block_number = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(11));
    q.byte_offset = 12'($urandom);
    q.chunk_length = 13'($urandom_range(4096, 1));
    q.fill_length = ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(4096));
    return q;
  endfunction

  // result side: random stalls, check on each accepted item
  always @(posedge clk) begin
    if (!rst && pop && !empty) board.check(result);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst || calm || $urandom_range(99) >= 8) pop <= 1;
      else begin
        pop <= 0;
        repeat ($urandom_range(18, 1) - 1) @(posedge clk);
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("block_cache_directory_random_evict regression: fail");
      $finish;
    end
  end

  initial begin
    board = new();
    cycles = 0;
    calm = 0;
    rst = 1;
    push = 0;
    pop = 0;
    request = '0;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < bcdre_pkg::MAX_ENTRIES; i++) begin
      dir_valid[i] = 0;
      dir_dirty[i] = 0;
    end
    dir_occ = 0;
    hits = 0;
    misses = 0;
    rand_state = 1;
    limit_reg = 64;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every request kind, zero fill, offset past length
    write_reg(bcdre_pkg::REG_BLOCK_LIMIT, 2);
    write_reg(bcdre_pkg::REG_RANDOM_SEED, 0);
    send_item(make_item(bcdre_pkg::REQ_READ, 0, 0, 0, 4096, 0));
    send_item(make_item(bcdre_pkg::REQ_READ, 10'h3FF, 32'hFFFF_FFFF, 12'hFFF, 4096, 8191));
    send_item(make_item(bcdre_pkg::REQ_READ, 10'h3FF, 32'hFFFF_FFFF, 0, 1, 0));
    send_item(make_item(bcdre_pkg::REQ_WRITE, 1, 5, 100, 4096, 0));
    send_item(make_item(bcdre_pkg::REQ_WRITE, 1, 5, 12'hFFF, 13'h1FFF, 0));
    send_item(make_item(bcdre_pkg::REQ_READ, 1, 5, 4000, 500, 0));
    send_item(make_item(bcdre_pkg::REQ_WRITE, 1, 6, 0, 8, 4096));
    send_item(make_item(bcdre_pkg::REQ_WRITE, 2, 7, 0, 8, 30));
    send_item(make_item(bcdre_pkg::REQ_READ, 1, 8, 40, 8, 20));
    send_item(make_item(bcdre_pkg::REQ_FLUSH, 1, 0, 0, 1, 0));
    send_item(make_item(bcdre_pkg::REQ_FLUSH, 1, 0, 0, 1, 0));
    send_item(make_item(bcdre_pkg::REQ_WRITE, 3, 1, 0, 1, 0));
    send_item(make_item(bcdre_pkg::REQ_CLEAR, 0, 0, 0, 1, 0));
    send_item(make_item(bcdre_pkg::REQ_DROP, 0, 0, 0, 1, 0));
    send_item(make_item(3'd7, 0, 0, 0, 1, 0));
    send_item(make_item(3'd5, 0, 0, 0, 1, 0));
    send_item(make_item(bcdre_pkg::REQ_READ, 3, 1, 0, 1, 1));

    // random phases over several limit and seed settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(bcdre_pkg::REG_BLOCK_LIMIT, 0);
        1: write_reg(bcdre_pkg::REG_BLOCK_LIMIT, 127);
        2: write_reg(bcdre_pkg::REG_BLOCK_LIMIT, 64);
        default: write_reg(bcdre_pkg::REG_BLOCK_LIMIT, $urandom_range(8, 1));
      endcase
      write_reg(bcdre_pkg::REG_RANDOM_SEED, (ph == 1) ? 32'hFFFF_FFFF : $urandom);
      if (ph == 5) calm = 1;
      for (int n = 0; n < 28; n++) begin
        send_item(random_item());
        if (n == 14 && ph == 3) drain_wait(0);
      end
    end

    drain_wait(400);
    if (board.errors == 0) $display("block_cache_directory_random_evict regression: pass");
    else $display("block_cache_directory_random_evict regression: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bcdre_pkg.sv
rtl/bcdre_ram.sv
rtl/bcdre_front.sv
rtl/bcdre_outq.sv
rtl/bcdre_back.sv
rtl/block_cache_directory_random_evict.sv
dv/tb_block_cache_directory_random_evict.sv
